// File: rtl/core/lkc_pkg.sv
package lkc_pkg;

   localparam int DEPTH      = 128;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CAP_W      = 8;
   localparam int OCC_W      = 8;
   localparam int STAT_W     = 32;
   localparam int CAP_RESET  = 100;

   // Cells are reduced in groups, then the group results are combined.
   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GIDX_W     = $clog2(GROUP_SIZE);
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_CLEAR  = 2'd1,
      FUNC_STATS  = 2'd2
   } func_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      logic take;
      logic kill;
   } cell_ctrl_type;

   typedef struct packed {
      logic      match;
      logic      last;
      entry_type entry;
   } cell_tap_type;

   typedef struct packed {
      logic                  hit;
      logic [GIDX_W-1:0]     idx;
      logic [VALUE_BITS-1:0] value;
      logic                  last;
      logic [KEY_BITS-1:0]   last_key;
   } group_sum_type;

   // A capacity of zero acts as one; anything above the store size saturates.
   function automatic logic [CNT_W-1:0] cap_eff(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] res;
      if (cap == '0) begin
         res = CNT_W'(1);
      end else if (int'(cap) > DEPTH) begin
         res = CNT_W'(DEPTH);
      end else begin
         res = CNT_W'(int'(cap));
      end
      return res;
   endfunction

endpackage

// File: rtl/core/lkc_ifs.sv
interface lkc_req_if;
   import lkc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [KEY_BITS-1:0]   lookup_key;
   logic [VALUE_BITS-1:0] fill_value;

   modport source (output valid, func, lookup_key, fill_value, input ready);
   modport sink   (input valid, func, lookup_key, fill_value, output ready);
endinterface

interface lkc_rsp_if;
   import lkc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [VALUE_BITS-1:0] result_value;
   logic                  evicted;
   logic [KEY_BITS-1:0]   evicted_key;
   logic [OCC_W-1:0]      occupancy;
   logic [STAT_W-1:0]     lookup_count;
   logic [STAT_W-1:0]     hit_count;
   logic [STAT_W-1:0]     miss_count;

   modport source (output valid, hit, result_value, evicted, evicted_key, occupancy,
                   lookup_count, hit_count, miss_count, input ready);
   modport sink   (input valid, hit, result_value, evicted, evicted_key, occupancy,
                   lookup_count, hit_count, miss_count, output ready);
endinterface

// File: rtl/core/lru_keyed_cache_unit.sv
// Fully associative key/value cache with least-recently-used replacement, built as a
// row of cells kept in recency order (the head cell is the most recent entry). Each
// transaction passes through the cycle it is accepted, a compare cycle in which every
// cell compares its key and the results are reduced in groups of sixteen, a cycle
// that combines the groups into the hit position, hit value and oldest key, and an
// update cycle in which the cells shift toward the tail by one place and the result
// is registered. A result that is not taken holds the update cycle until the output
// slot frees. A capacity write trims the surplus tail cells in the cycle it is written,
// and no clearing pass is needed after reset.
module lru_keyed_cache_unit (
   input  logic                       clock,
   input  logic                       reset,
   lkc_req_if.sink                    req_port,
   lkc_rsp_if.source                  rsp_port,
   input  logic                       csr_we,
   input  logic [lkc_pkg::CAP_W-1:0]  csr_wdata
);
   import lkc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_SEL,
      ST_UPD
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]            req_func_ff, req_func_in;
   logic [KEY_BITS-1:0]   req_key_ff, req_key_in;
   logic [VALUE_BITS-1:0] req_fill_ff, req_fill_in;

   logic                  sel_hit_ff, sel_hit_in;
   logic [IDX_W-1:0]      sel_pos_ff, sel_pos_in;
   logic [VALUE_BITS-1:0] sel_value_ff, sel_value_in;
   logic [KEY_BITS-1:0]   sel_victim_ff, sel_victim_in;

   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [STAT_W-1:0]     lookups_ff, lookups_in;
   logic [STAT_W-1:0]     hits_ff, hits_in;
   logic [STAT_W-1:0]     misses_ff, misses_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_BITS-1:0]   rsp_victim_ff, rsp_victim_in;

   logic                  upd_lookup;
   logic                  upd_clear;
   logic [IDX_W-1:0]      upd_limit;
   logic                  evict;
   logic [CNT_W-1:0]      cur_cap;
   logic [CNT_W-1:0]      new_cap;
   entry_type             head_entry;

   logic [DEPTH-1:0]      valid_vec;
   cell_tap_type          taps [NUM_GROUPS][GROUP_SIZE];
   group_sum_type         sums [NUM_GROUPS];

   assign cur_cap = cap_eff(cap_ff);
   assign new_cap = cap_eff(csr_wdata);
   assign evict   = !sel_hit_ff && (count_ff >= cur_cap);

   // On a hit the cells up to the hit position shift; on a miss the whole valid run
   // shifts, and when the store is full the last valid cell is overwritten.
   always_comb begin
      if (sel_hit_ff) begin
         upd_limit = sel_pos_ff;
      end else if (evict) begin
         upd_limit = IDX_W'(count_ff - CNT_W'(1));
      end else begin
         upd_limit = IDX_W'(count_ff);
      end
   end

   assign head_entry.key   = req_key_ff;
   assign head_entry.value = sel_hit_ff ? sel_value_ff : req_fill_ff;

   // Cell row.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     prev_entry;
      logic          prev_valid;
      logic          next_valid;
      cell_tap_type  tap;

      assign ctrl.take = upd_lookup && (IDX_W'(i) <= upd_limit);
      assign ctrl.kill = upd_clear || (csr_we && (CNT_W'(i) >= new_cap));

      if (i == 0) begin : g_head
         assign prev_entry = head_entry;
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_entry = g_cell[i-1].tap.entry;
         assign prev_valid = valid_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_valid = 1'b0;
      end else begin : g_inner
         assign next_valid = valid_vec[i+1];
      end

      lkc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry (prev_entry),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .probe_key  (req_key_ff),
         .valid      (valid_vec[i]),
         .tap        (tap)
      );

      assign taps[i / GROUP_SIZE][i % GROUP_SIZE] = tap;
   end

   for (genvar i = DEPTH; i < NUM_GROUPS * GROUP_SIZE; i++) begin : g_pad
      assign taps[i / GROUP_SIZE][i % GROUP_SIZE] = '0;
   end

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      lkc_group u_group (
         .clock (clock),
         .taps  (taps[g]),
         .sum   (sums[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      req_func_in   = req_func_ff;
      req_key_in    = req_key_ff;
      req_fill_in   = req_fill_ff;
      sel_hit_in    = sel_hit_ff;
      sel_pos_in    = sel_pos_ff;
      sel_value_in  = sel_value_ff;
      sel_victim_in = sel_victim_ff;
      cap_in        = cap_ff;
      count_in      = count_ff;
      lookups_in    = lookups_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_victim_in  = rsp_victim_ff;
      upd_lookup    = 1'b0;
      upd_clear     = 1'b0;

      if (csr_we) begin
         cap_in   = csr_wdata;
         count_in = (count_ff > new_cap) ? new_cap : count_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               req_func_in = req_port.func;
               req_key_in  = req_port.lookup_key;
               req_fill_in = req_port.fill_value;
               state_in    = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_SEL;
         end
         ST_SEL: begin
            sel_hit_in    = 1'b0;
            sel_pos_in    = '0;
            sel_value_in  = '0;
            sel_victim_in = '0;
            for (int g = 0; g < NUM_GROUPS; g++) begin
               if (sums[g].hit) begin
                  sel_hit_in   = 1'b1;
                  sel_pos_in   = sel_pos_in | IDX_W'(g * GROUP_SIZE + int'(sums[g].idx));
                  sel_value_in = sel_value_in | sums[g].value;
               end
               if (sums[g].last) begin
                  sel_victim_in = sel_victim_in | sums[g].last_key;
               end
            end
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = 1'b0;
               rsp_value_in   = '0;
               rsp_evicted_in = 1'b0;
               rsp_victim_in  = '0;
               unique case (req_func_ff)
                  FUNC_LOOKUP: begin
                     upd_lookup = 1'b1;
                     lookups_in = lookups_ff + STAT_W'(1);
                     if (sel_hit_ff) begin
                        hits_in      = hits_ff + STAT_W'(1);
                        rsp_hit_in   = 1'b1;
                        rsp_value_in = sel_value_ff;
                     end else begin
                        misses_in    = misses_ff + STAT_W'(1);
                        rsp_value_in = req_fill_ff;
                        if (evict) begin
                           rsp_evicted_in = 1'b1;
                           rsp_victim_in  = sel_victim_ff;
                        end else begin
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  FUNC_CLEAR: begin
                     upd_clear = 1'b1;
                     count_in  = '0;
                  end
                  FUNC_STATS: begin
                     lookups_in = '0;
                     hits_in    = '0;
                     misses_in  = '0;
                  end
                  default: begin
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_func_ff    <= req_func_in;
      req_key_ff     <= req_key_in;
      req_fill_ff    <= req_fill_in;
      sel_hit_ff     <= sel_hit_in;
      sel_pos_ff     <= sel_pos_in;
      sel_value_ff   <= sel_value_in;
      sel_victim_ff  <= sel_victim_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_victim_ff  <= rsp_victim_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_W'(CAP_RESET);
         count_ff     <= '0;
         lookups_ff   <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         lookups_ff   <= lookups_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_port.ready        = (state_ff == ST_IDLE);
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.hit          = rsp_hit_ff;
   assign rsp_port.result_value = rsp_value_ff;
   assign rsp_port.evicted      = rsp_evicted_ff;
   assign rsp_port.evicted_key  = rsp_victim_ff;
   assign rsp_port.occupancy    = OCC_W'(count_ff);
   assign rsp_port.lookup_count = lookups_ff;
   assign rsp_port.hit_count    = hits_ff;
   assign rsp_port.miss_count   = misses_ff;

`ifndef SYNTH
   // The entry count tracks the number of valid cells.
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count differs from the number of valid cells");

   // Valid cells form one unbroken run starting at the head cell.
   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
      else $error("valid cells are not packed from the head");

   a_count_within_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cur_cap)
      else $error("entry count exceeds the effective capacity");

   // A new response is only ever produced by the update cycle.
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_UPD)
      else $error("response raised outside the update cycle");
`endif

endmodule

// File: rtl/core/lkc_cell.sv
module lkc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  lkc_pkg::cell_ctrl_type        ctrl,
   input  lkc_pkg::entry_type            prev_entry,
   input  logic                          prev_valid,
   input  logic                          next_valid,
   input  logic [lkc_pkg::KEY_BITS-1:0]  probe_key,
   output logic                          valid,
   output lkc_pkg::cell_tap_type         tap
);
   import lkc_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      priority if (ctrl.kill) begin
         valid_in = 1'b0;
      end else if (ctrl.take) begin
         valid_in = prev_valid;
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Valid cells are packed from the head, so the oldest one is the last valid cell.
   assign valid     = valid_ff;
   assign tap.match = valid_ff && (entry_ff.key == probe_key);
   assign tap.last  = valid_ff && !next_valid;
   assign tap.entry = entry_ff;

endmodule

// File: rtl/core/lkc_group.sv
module lkc_group (
   input  logic                   clock,
   input  lkc_pkg::cell_tap_type  taps [lkc_pkg::GROUP_SIZE],
   output lkc_pkg::group_sum_type sum
);
   import lkc_pkg::*;

   group_sum_type sum_ff, sum_in;

   // At most one cell matches and at most one is the last valid one, so OR is a select.
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
         if (taps[j].match) begin
            sum_in.hit   = 1'b1;
            sum_in.idx   = sum_in.idx | GIDX_W'(j);
            sum_in.value = sum_in.value | taps[j].entry.value;
         end
         if (taps[j].last) begin
            sum_in.last     = 1'b1;
            sum_in.last_key = sum_in.last_key | taps[j].entry.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

// File: tb/tb_lru_keyed_cache_unit.sv
module tb_lru_keyed_cache_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lkc_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int HALF_PERIOD  = 6;
   localparam int SETTLE_CYCLES = 10;
   localparam int LIMIT_CYCLES = 400000;
   localparam int MAX_PRINTS   = 60;
   localparam int PHASE_ITEMS  = 175;
   localparam int POOL_MAX     = 320;

   typedef struct {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } cached_entry_type;

   typedef struct {
      logic                  hit;
      logic [VALUE_BITS-1:0] value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
      logic [OCC_W-1:0]      occupancy;
      logic [STAT_W-1:0]     lookups;
      logic [STAT_W-1:0]     hits;
      logic [STAT_W-1:0]     misses;
   } cache_rsp_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CAP_W-1:0] csr_wdata;

   lkc_req_if req_bus ();
   lkc_rsp_if rsp_bus ();

   lru_keyed_cache_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the store, most recent entry at the front.
   cached_entry_type   recency_list[$];
   logic [CAP_W-1:0]   capacity_setting;
   logic [STAT_W-1:0]  lookup_total;
   logic [STAT_W-1:0]  hit_total;
   logic [STAT_W-1:0]  miss_total;

   cache_rsp_type expected_responses[$];
   int error_count;
   int cycle_count;
   int burst_left;
   bit sender_gaps;
   logic [15:0] ready_word;
   logic [5:0]  ready_tick;
   logic [KEY_BITS-1:0] key_pool[POOL_MAX];

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic int usable_capacity();
      int c;
      c = int'(capacity_setting);
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic cache_rsp_type lru_response(input logic [1:0] op,
                                                  input logic [KEY_BITS-1:0] key,
                                                  input logic [VALUE_BITS-1:0] fill);
      cache_rsp_type rsp;
      cached_entry_type ent;
      int pos;
      rsp = '{default: '0};
      case (op)
         FUNC_LOOKUP: begin
            lookup_total++;
            pos = -1;
            foreach (recency_list[i]) begin
               if (pos < 0 && recency_list[i].key == key) pos = i;
            end
            if (pos >= 0) begin
               ent = recency_list[pos];
               recency_list.delete(pos);
               recency_list.push_front(ent);
               hit_total++;
               rsp.hit = 1'b1;
               rsp.value = ent.value;
            end else begin
               if (recency_list.size() >= usable_capacity()) begin
                  rsp.evicted = 1'b1;
                  rsp.evicted_key = recency_list[$].key;
                  recency_list.pop_back();
               end
               ent.key = key;
               ent.value = fill;
               recency_list.push_front(ent);
               miss_total++;
               rsp.value = fill;
            end
         end
         FUNC_CLEAR: recency_list.delete();
         FUNC_STATS: begin
            lookup_total = '0;
            hit_total = '0;
            miss_total = '0;
         end
         default: ;
      endcase
      rsp.occupancy = OCC_W'(recency_list.size());
      rsp.lookups = lookup_total;
      rsp.hits = hit_total;
      rsp.misses = miss_total;
      return rsp;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want)
         report_error($sformatf("%s expected 0x%0h, got 0x%0h", field, want, got));
   endtask

   task automatic send_request(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                               input logic [VALUE_BITS-1:0] fill);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.func       <= op;
      req_bus.lookup_key <= key;
      req_bus.fill_value <= fill;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_responses.insert(expected_responses.size(), lru_response(op, key, fill));
      if (burst_left > 0) burst_left--;
   endtask

   // Holds the sender off until the block has answered everything in flight.
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_results();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(negedge clock);
      csr_we    <= 1'b0;
      capacity_setting = cap;
      while (recency_list.size() > usable_capacity()) recency_list.pop_back();
   endtask

   task automatic test_basic_functions();
      send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h1234_5678);
      send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(FUNC_UNUSED, 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(FUNC_STATS, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(FUNC_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(FUNC_CLEAR, 32'h0000_0000, 32'h0000_0000);
      send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0001);
   endtask

   // A zero capacity acts as one; a hit must move its entry away from the victim slot.
   task automatic test_eviction_order();
      write_capacity(8'd0);
      send_request(FUNC_LOOKUP, 32'h0000_0011, 32'hC0DE_0011);
      send_request(FUNC_LOOKUP, 32'h0000_0022, 32'hC0DE_0022);
      send_request(FUNC_LOOKUP, 32'h0000_0022, 32'h0000_0000);
      write_capacity(8'd3);
      send_request(FUNC_LOOKUP, 32'h0000_0033, 32'hC0DE_0033);
      send_request(FUNC_LOOKUP, 32'h0000_0044, 32'hC0DE_0044);
      send_request(FUNC_LOOKUP, 32'h0000_0022, 32'h0000_0000);
      send_request(FUNC_LOOKUP, 32'h0000_0055, 32'hC0DE_0055);
   endtask

   task automatic test_capacity_trim();
      write_capacity(8'd128);
      for (int k = 0; k < 4; k++)
         send_request(FUNC_LOOKUP, 32'h0001_0000 + k, 32'hBEEF_0000 + k);
      write_capacity(8'd2);
      send_request(FUNC_LOOKUP, 32'h0001_0003, 32'h0000_0000);
      send_request(FUNC_LOOKUP, 32'h0001_0000, 32'h0000_0000);
   endtask

   task automatic test_random_traffic();
      logic [CAP_W-1:0] phase_caps[10];
      int pool_n;
      int pick;
      logic [1:0] op;
      logic [KEY_BITS-1:0] key;
      phase_caps = '{8'd100, 8'd255, 8'd1, 8'd128, 8'd0, 8'd7, 8'd2, 8'd64, 8'd0, 8'd127};
      phase_caps[8] = CAP_W'($urandom_range(1, 255));
      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p]);
         sender_gaps = (p % 3 != 0);
         pool_n = usable_capacity() * 3 / 2 + 2;
         if (pool_n > POOL_MAX) pool_n = POOL_MAX;
         foreach (key_pool[i]) key_pool[i] = $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 399);
            if (pick < 2) op = FUNC_CLEAR;
            else if (pick < 6) op = FUNC_STATS;
            else if (pick < 10) op = FUNC_UNUSED;
            else op = FUNC_LOOKUP;
            if ($urandom_range(0, 9) == 0) key = $urandom;
            else key = key_pool[$urandom_range(0, pool_n - 1)];
            send_request(op, key, $urandom);
            if ($urandom_range(0, 199) == 0) drain_results();
         end
      end
   endtask

   // Receiver: a random ready pattern from a 16-bit word, sometimes all ready, reloaded when the 6-bit tick wraps.
   always @(negedge clock) begin
      if (ready_tick == 6'd0)
         ready_word = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      rsp_bus.ready <= ready_word[ready_tick[3:0]];
      ready_tick = ready_tick + 6'd1;
   end

   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_responses.size() == 0) begin
            report_error("response transaction with no request outstanding");
         end else begin
            want = expected_responses.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_bus.hit));
            check_field("result_value", want.value, rsp_bus.result_value);
            check_field("evicted", 32'(want.evicted), 32'(rsp_bus.evicted));
            // The victim key only carries meaning when an entry was actually removed.
            if (want.evicted)
               check_field("evicted_key", want.evicted_key, rsp_bus.evicted_key);
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_bus.occupancy));
            check_field("lookup_count", want.lookups, rsp_bus.lookup_count);
            check_field("hit_count", want.hits, rsp_bus.hit_count);
            check_field("miss_count", want.misses, rsp_bus.miss_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout with %0d responses outstanding", expected_responses.size());
         $display("lru_keyed_cache_unit test failed");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.func       = FUNC_LOOKUP;
      req_bus.lookup_key = '0;
      req_bus.fill_value = '0;
      rsp_bus.ready      = 1'b0;
      ready_word         = 16'hFFFF;
      ready_tick         = '0;
      error_count        = 0;
      cycle_count        = 0;
      burst_left         = 0;
      sender_gaps        = 1'b1;
      capacity_setting   = CAP_W'(CAP_RESET);
      lookup_total       = '0;
      hit_total          = '0;
      miss_total         = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_functions();
      test_eviction_order();
      test_capacity_trim();
      test_random_traffic();

      drain_results();
      if (error_count == 0) begin
         $display("lru_keyed_cache_unit test passed");
      end else begin
         $display("lru_keyed_cache_unit test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/lkc_pkg.sv
rtl/core/lkc_ifs.sv
rtl/core/lkc_cell.sv
rtl/core/lkc_group.sv
rtl/core/lru_keyed_cache_unit.sv
tb/tb_lru_keyed_cache_unit.sv
